// ===== rtl/core/zuc_pkg.sv =====
// zuc_pkg: shared types, constants and helper functions for the ZUC-128 word core.
// S-boxes, D constants, linear transforms and the mod 2^31-1 adder.
// No dependencies.
`timescale 1ns / 1ps

package zuc_pkg;

    localparam logic OP_INIT = 1'b0;
    localparam logic OP_WORD = 1'b1;

    localparam logic [1:0] CFG_KEY_HIGH = 2'd0;
    localparam logic [1:0] CFG_KEY_LOW  = 2'd1;
    localparam logic [1:0] CFG_IV_HIGH  = 2'd2;
    localparam logic [1:0] CFG_IV_LOW   = 2'd3;

    localparam logic [5:0]  INIT_ROUNDS = 6'd32;
    localparam logic [30:0] M31         = 31'h7FFFFFFF;

    // feedback term selector inside one round
    localparam logic [2:0] STEP_C4    = 3'd0;
    localparam logic [2:0] STEP_C10   = 3'd1;
    localparam logic [2:0] STEP_C13   = 3'd2;
    localparam logic [2:0] STEP_C15   = 3'd3;
    localparam logic [2:0] STEP_C0    = 3'd4;
    localparam logic [2:0] STEP_U     = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_FSM,
        ST_ADD
    } state_t;

    typedef struct packed {
        logic load;       // fill cells from key/iv, clear R1/R2
        logic f_run;      // run F, latch W, seed accumulator
        logic acc_add;    // fold one feedback term
        logic round_end;  // shift LFSR with the finished feedback
        logic emit;       // present a result word
    } ctrl_t;

    localparam logic [14:0] DCONST [0:15] = '{
        15'h44D7, 15'h26BC, 15'h626B, 15'h135E, 15'h5789, 15'h35E2, 15'h7135, 15'h09AF,
        15'h4D78, 15'h2F13, 15'h6BC4, 15'h1AF1, 15'h5E26, 15'h3C4D, 15'h789A, 15'h47AC
    };

    localparam logic [7:0] SBOX0 [0:255] = '{
        8'h3e,8'h72,8'h5b,8'h47,8'hca,8'he0,8'h00,8'h33,8'h04,8'hd1,8'h54,8'h98,8'h09,8'hb9,8'h6d,8'hcb,
        8'h7b,8'h1b,8'hf9,8'h32,8'haf,8'h9d,8'h6a,8'ha5,8'hb8,8'h2d,8'hfc,8'h1d,8'h08,8'h53,8'h03,8'h90,
        8'h4d,8'h4e,8'h84,8'h99,8'he4,8'hce,8'hd9,8'h91,8'hdd,8'hb6,8'h85,8'h48,8'h8b,8'h29,8'h6e,8'hac,
        8'hcd,8'hc1,8'hf8,8'h1e,8'h73,8'h43,8'h69,8'hc6,8'hb5,8'hbd,8'hfd,8'h39,8'h63,8'h20,8'hd4,8'h38,
        8'h76,8'h7d,8'hb2,8'ha7,8'hcf,8'hed,8'h57,8'hc5,8'hf3,8'h2c,8'hbb,8'h14,8'h21,8'h06,8'h55,8'h9b,
        8'he3,8'hef,8'h5e,8'h31,8'h4f,8'h7f,8'h5a,8'ha4,8'h0d,8'h82,8'h51,8'h49,8'h5f,8'hba,8'h58,8'h1c,
        8'h4a,8'h16,8'hd5,8'h17,8'ha8,8'h92,8'h24,8'h1f,8'h8c,8'hff,8'hd8,8'hae,8'h2e,8'h01,8'hd3,8'had,
        8'h3b,8'h4b,8'hda,8'h46,8'heb,8'hc9,8'hde,8'h9a,8'h8f,8'h87,8'hd7,8'h3a,8'h80,8'h6f,8'h2f,8'hc8,
        8'hb1,8'hb4,8'h37,8'hf7,8'h0a,8'h22,8'h13,8'h28,8'h7c,8'hcc,8'h3c,8'h89,8'hc7,8'hc3,8'h96,8'h56,
        8'h07,8'hbf,8'h7e,8'hf0,8'h0b,8'h2b,8'h97,8'h52,8'h35,8'h41,8'h79,8'h61,8'ha6,8'h4c,8'h10,8'hfe,
        8'hbc,8'h26,8'h95,8'h88,8'h8a,8'hb0,8'ha3,8'hfb,8'hc0,8'h18,8'h94,8'hf2,8'he1,8'he5,8'he9,8'h5d,
        8'hd0,8'hdc,8'h11,8'h66,8'h64,8'h5c,8'hec,8'h59,8'h42,8'h75,8'h12,8'hf5,8'h74,8'h9c,8'haa,8'h23,
        8'h0e,8'h86,8'hab,8'hbe,8'h2a,8'h02,8'he7,8'h67,8'he6,8'h44,8'ha2,8'h6c,8'hc2,8'h93,8'h9f,8'hf1,
        8'hf6,8'hfa,8'h36,8'hd2,8'h50,8'h68,8'h9e,8'h62,8'h71,8'h15,8'h3d,8'hd6,8'h40,8'hc4,8'he2,8'h0f,
        8'h8e,8'h83,8'h77,8'h6b,8'h25,8'h05,8'h3f,8'h0c,8'h30,8'hea,8'h70,8'hb7,8'ha1,8'he8,8'ha9,8'h65,
        8'h8d,8'h27,8'h1a,8'hdb,8'h81,8'hb3,8'ha0,8'hf4,8'h45,8'h7a,8'h19,8'hdf,8'hee,8'h78,8'h34,8'h60
    };

    localparam logic [7:0] SBOX1 [0:255] = '{
        8'h55,8'hc2,8'h63,8'h71,8'h3b,8'hc8,8'h47,8'h86,8'h9f,8'h3c,8'hda,8'h5b,8'h29,8'haa,8'hfd,8'h77,
        8'h8c,8'hc5,8'h94,8'h0c,8'ha6,8'h1a,8'h13,8'h00,8'he3,8'ha8,8'h16,8'h72,8'h40,8'hf9,8'hf8,8'h42,
        8'h44,8'h26,8'h68,8'h96,8'h81,8'hd9,8'h45,8'h3e,8'h10,8'h76,8'hc6,8'ha7,8'h8b,8'h39,8'h43,8'he1,
        8'h3a,8'hb5,8'h56,8'h2a,8'hc0,8'h6d,8'hb3,8'h05,8'h22,8'h66,8'hbf,8'hdc,8'h0b,8'hfa,8'h62,8'h48,
        8'hdd,8'h20,8'h11,8'h06,8'h36,8'hc9,8'hc1,8'hcf,8'hf6,8'h27,8'h52,8'hbb,8'h69,8'hf5,8'hd4,8'h87,
        8'h7f,8'h84,8'h4c,8'hd2,8'h9c,8'h57,8'ha4,8'hbc,8'h4f,8'h9a,8'hdf,8'hfe,8'hd6,8'h8d,8'h7a,8'heb,
        8'h2b,8'h53,8'hd8,8'h5c,8'ha1,8'h14,8'h17,8'hfb,8'h23,8'hd5,8'h7d,8'h30,8'h67,8'h73,8'h08,8'h09,
        8'hee,8'hb7,8'h70,8'h3f,8'h61,8'hb2,8'h19,8'h8e,8'h4e,8'he5,8'h4b,8'h93,8'h8f,8'h5d,8'hdb,8'ha9,
        8'had,8'hf1,8'hae,8'h2e,8'hcb,8'h0d,8'hfc,8'hf4,8'h2d,8'h46,8'h6e,8'h1d,8'h97,8'he8,8'hd1,8'he9,
        8'h4d,8'h37,8'ha5,8'h75,8'h5e,8'h83,8'h9e,8'hab,8'h82,8'h9d,8'hb9,8'h1c,8'he0,8'hcd,8'h49,8'h89,
        8'h01,8'hb6,8'hbd,8'h58,8'h24,8'ha2,8'h5f,8'h38,8'h78,8'h99,8'h15,8'h90,8'h50,8'hb8,8'h95,8'he4,
        8'hd0,8'h91,8'hc7,8'hce,8'hed,8'h0f,8'hb4,8'h6f,8'ha0,8'hcc,8'hf0,8'h02,8'h4a,8'h79,8'hc3,8'hde,
        8'ha3,8'hef,8'hea,8'h51,8'he6,8'h6b,8'h18,8'hec,8'h1b,8'h2c,8'h80,8'hf7,8'h74,8'he7,8'hff,8'h21,
        8'h5a,8'h6a,8'h54,8'h1e,8'h41,8'h31,8'h92,8'h35,8'hc4,8'h33,8'h07,8'h0a,8'hba,8'h7e,8'h0e,8'h34,
        8'h88,8'hb1,8'h98,8'h7c,8'hf3,8'h3d,8'h60,8'h6c,8'h7b,8'hca,8'hd3,8'h1f,8'h32,8'h65,8'h04,8'h28,
        8'h64,8'hbe,8'h85,8'h9b,8'h2f,8'h59,8'h8a,8'hd7,8'hb0,8'h25,8'hac,8'haf,8'h12,8'h03,8'he2,8'hf2
    };

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int k);
        return (x << k) | (x >> (32 - k));
    endfunction

    function automatic logic [30:0] rotl31(input logic [30:0] x, input int k);
        return (x << k) | (x >> (31 - k));
    endfunction

    function automatic logic [31:0] lin1(input logic [31:0] x);
        return x ^ rotl32(x, 2) ^ rotl32(x, 10) ^ rotl32(x, 18) ^ rotl32(x, 24);
    endfunction

    function automatic logic [31:0] lin2(input logic [31:0] x);
        return x ^ rotl32(x, 8) ^ rotl32(x, 14) ^ rotl32(x, 22) ^ rotl32(x, 30);
    endfunction

    function automatic logic [31:0] subst(input logic [31:0] x);
        return {SBOX0[x[31:24]], SBOX1[x[23:16]], SBOX0[x[15:8]], SBOX1[x[7:0]]};
    endfunction

    // end-around carry add, result stays within 31 bits
    function automatic logic [30:0] add_m31(input logic [30:0] a, input logic [30:0] b);
        logic [31:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[30:0] + {30'd0, s[31]};
    endfunction

endpackage

// ===== rtl/core/zuc_fsm_f.sv =====
// zuc_fsm_f: nonlinear function F of the ZUC core (one evaluation per call).
// Takes the reorganized words X0..X2 and R1/R2, returns W and the next R1/R2.
// Depends on zuc_pkg (S-boxes, L1, L2).
`timescale 1ns / 1ps

module zuc_fsm_f (
    input  logic [31:0] bx0,
    input  logic [31:0] bx1,
    input  logic [31:0] bx2,
    input  logic [31:0] r1,
    input  logic [31:0] r2,
    output logic [31:0] w,
    output logic [31:0] r1_new,
    output logic [31:0] r2_new
);
    import zuc_pkg::*;

    logic [31:0] w1;
    logic [31:0] w2;

    assign w      = (bx0 ^ r1) + r2;
    assign w1     = r1 + bx1;
    assign w2     = r2 ^ bx2;
    assign r1_new = subst(lin1({w1[15:0], w2[31:16]}));
    assign r2_new = subst(lin2({w2[15:0], w1[31:16]}));

endmodule

// ===== rtl/core/zuc_stream_cipher_word.sv =====
// zuc_stream_cipher_word: ZUC-128 keystream core, one data word per item.
// Sequencer, LFSR cells, R1/R2 and a single shared mod 2^31-1 adder.
// Depends on zuc_pkg and zuc_fsm_f.
//
//  port group   direction  handshake            payload
//  in           input      in_valid/in_ready    opcode, data_word
//  out          output     out_valid/out_ready  result_word
//  cfg          input      cfg_we               cfg_index, cfg_data
//
// One round = F step + five adder steps (six with the init feedback term W>>1).
// An item is accepted only in idle, once the last one has finished. Init: accept, load,
// 32 init rounds, then one work round. The shared adder folds one LFSR feedback term
// per cycle, except while a stall holds back the last term of a round.
// Reset clears cells, R1/R2, key and iv. A result waiting on out_ready
// holds the next data word in its last adder cycle; init items never wait.
`timescale 1ns / 1ps

module zuc_stream_cipher_word (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [31:0] data_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] result_word,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import zuc_pkg::*;

    state_t      state_reg, state_next;
    ctrl_t       ctrl;

    logic [63:0] key_high_reg, key_low_reg, iv_high_reg, iv_low_reg;
    logic [30:0] cells_reg [0:15];
    logic [31:0] r1_reg, r2_reg;
    logic [31:0] w_reg, bx3_reg;
    logic [30:0] acc_reg;
    logic [2:0]  step_reg;
    logic [5:0]  round_reg;
    logic        op_reg;
    logic [31:0] data_reg;
    logic        out_valid_reg;
    logic [31:0] result_reg;

    logic [31:0] bx0, bx1, bx2, bx3;
    logic [31:0] f_w, f_r1, f_r2;
    logic [30:0] term, acc_sum, fb;
    logic        init_round, last_step, stall, accept;

    assign accept     = in_valid && in_ready;
    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign result_word = result_reg;

    // bit reorganization
    assign bx0 = {cells_reg[15][30:15], cells_reg[14][15:0]};
    assign bx1 = {cells_reg[11][15:0], cells_reg[9][30:15]};
    assign bx2 = {cells_reg[7][15:0], cells_reg[5][30:15]};
    assign bx3 = {cells_reg[2][15:0], cells_reg[0][30:15]};

    zuc_fsm_f u_f (
        .bx0    (bx0),
        .bx1    (bx1),
        .bx2    (bx2),
        .r1     (r1_reg),
        .r2     (r2_reg),
        .w      (f_w),
        .r1_new (f_r1),
        .r2_new (f_r2)
    );

    assign init_round = (op_reg == OP_INIT) && (round_reg < INIT_ROUNDS);
    assign last_step  = init_round ? (step_reg == STEP_U) : (step_reg == STEP_C0);
    assign stall      = (op_reg == OP_WORD) && out_valid_reg && !out_ready;

    always_comb
    begin
        unique case (step_reg)
            STEP_C4:  term = rotl31(cells_reg[4], 20);
            STEP_C10: term = rotl31(cells_reg[10], 21);
            STEP_C13: term = rotl31(cells_reg[13], 17);
            STEP_C15: term = rotl31(cells_reg[15], 15);
            STEP_C0:  term = rotl31(cells_reg[0], 8);
            STEP_U:   term = w_reg[31:1];
            default:  term = '0;
        endcase
    end

    assign acc_sum = add_m31(acc_reg, term);
    assign fb      = (acc_sum == '0) ? M31 : acc_sum;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (opcode == OP_INIT) ? ST_LOAD : ST_FSM;
                end
            end
            ST_LOAD: state_next = ST_FSM;
            ST_FSM:  state_next = ST_ADD;
            ST_ADD:
            begin
                if (last_step && !stall)
                begin
                    state_next = init_round ? ST_FSM : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        ctrl = '0;
        unique case (state_reg)
            ST_IDLE: ctrl = '0;
            ST_LOAD: ctrl.load = 1'b1;
            ST_FSM:  ctrl.f_run = 1'b1;
            ST_ADD:
            begin
                ctrl.acc_add   = !(last_step && stall);
                ctrl.round_end = last_step && !stall;
                ctrl.emit      = last_step && !stall && (op_reg == OP_WORD);
            end
            default: ctrl = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            key_high_reg  <= '0;
            key_low_reg   <= '0;
            iv_high_reg   <= '0;
            iv_low_reg    <= '0;
            for (int i = 0; i < 16; i++)
            begin
                cells_reg[i] <= '0;
            end
            r1_reg        <= '0;
            r2_reg        <= '0;
            step_reg      <= '0;
            round_reg     <= '0;
            op_reg        <= OP_WORD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_KEY_HIGH: key_high_reg <= cfg_data;
                    CFG_KEY_LOW:  key_low_reg  <= cfg_data;
                    CFG_IV_HIGH:  iv_high_reg  <= cfg_data;
                    CFG_IV_LOW:   iv_low_reg   <= cfg_data;
                    default:      ;
                endcase
            end

            if (accept)
            begin
                op_reg    <= opcode;
                round_reg <= '0;
            end

            if (ctrl.load)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    cells_reg[i]     <= {key_high_reg[63 - 8*i -: 8], DCONST[i],
                                         iv_high_reg[63 - 8*i -: 8]};
                    cells_reg[i + 8] <= {key_low_reg[63 - 8*i -: 8], DCONST[i + 8],
                                         iv_low_reg[63 - 8*i -: 8]};
                end
                r1_reg <= '0;
                r2_reg <= '0;
            end

            if (ctrl.f_run)
            begin
                r1_reg   <= f_r1;
                r2_reg   <= f_r2;
                step_reg <= STEP_C4;
            end
            else if (ctrl.acc_add)
            begin
                step_reg <= step_reg + 3'd1;
            end

            if (ctrl.round_end)
            begin
                for (int i = 0; i < 15; i++)
                begin
                    cells_reg[i] <= cells_reg[i + 1];
                end
                cells_reg[15] <= fb;
                if (init_round)
                begin
                    round_reg <= round_reg + 6'd1;
                end
            end

            if (ctrl.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= data_word;
        end
        if (ctrl.f_run)
        begin
            w_reg   <= f_w;
            bx3_reg <= bx3;
            acc_reg <= cells_reg[0];
        end
        else if (ctrl.acc_add)
        begin
            acc_reg <= acc_sum;
        end
        if (ctrl.emit)
        begin
            result_reg <= data_reg ^ w_reg ^ bx3_reg;
        end
    end

endmodule
